@@ rtl/bfc_pkg.sv @@
// Package for the bigram frequency counter.
// Holds default sizes and the command codes passed from front to back.
// No dependencies.
package bfc_pkg;

  localparam int unsigned TokenBitsDef    = 16;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned CountBitsDef    = 16;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned FieldBits       = 16;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_FIRST = 2'd0,  // first token, forms no bigram
    CMD_PUSH  = 2'd1,  // bigram to count
    CMD_QUERY = 2'd2   // pair lookup
  } cmd_kind_e;

  localparam int unsigned KindBits = 2;

endpackage

@@ rtl/bfc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bfc_front.sv @@
// Front end: takes command beats, tracks the previous token, classifies.
// Depends on bfc_pkg.
module bfc_front
  import bfc_pkg::*;
#(
  parameter int unsigned TOKEN_BITS = TokenBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    action_i,
  input  logic [FieldBits-1:0]    token_i,
  input  logic [FieldBits-1:0]    query_first_i,
  input  logic [FieldBits-1:0]    query_second_i,
  output cmd_kind_e               kind_o,
  output logic [2*TOKEN_BITS-1:0] key_o
);

  logic [TOKEN_BITS-1:0] prev_q, prev_d;
  logic                  have_prev_q, have_prev_d;
  logic [TOKEN_BITS-1:0] tok;

  assign tok = TOKEN_BITS'(token_i);

  // Classify the beat and form the pair key
  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    if (action_i) begin
      kind_o = CMD_QUERY;
      key_o  = {TOKEN_BITS'(query_first_i), TOKEN_BITS'(query_second_i)};
    end else begin
      kind_o = have_prev_q ? CMD_PUSH : CMD_FIRST;
      key_o  = {prev_q, tok};
      if (accept_i) begin
        prev_d      = tok;
        have_prev_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

@@ rtl/bfc_queue.sv @@
// Short first-word-fall-through queue between front and back.
// Depends on bfc_pkg.
module bfc_queue
  import bfc_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = slot_q[rptr_q];

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/bfc_back.sv @@
// Back end: scans the pair table one entry a cycle, counts, allocates,
// tracks the best pair and drives the result beat. Depends on bfc_pkg, bfc_ram.
module bfc_back
  import bfc_pkg::*;
#(
  parameter int unsigned TOKEN_BITS    = TokenBitsDef,
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned COUNT_BITS    = CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  cmd_kind_e               cmd_kind_i,
  input  logic [2*TOKEN_BITS-1:0] cmd_key_i,
  output logic                    cmd_pop_o,
  output logic                    done_o,
  output logic [COUNT_BITS-1:0]   pair_count_o,
  output logic [COUNT_BITS-1:0]   total_o,
  output logic [2*TOKEN_BITS-1:0] best_key_o,
  output logic [COUNT_BITS-1:0]   best_count_o,
  output logic                    overflow_o
);

  localparam int unsigned KW = 2 * TOKEN_BITS;
  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW = KW + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                state_q, state_d;
  cmd_kind_e             kind_q, kind_d, act_kind;
  logic [KW-1:0]         key_q, key_d, act_key;
  logic [AW-1:0]         idx_q, idx_d;
  logic [UW-1:0]         used_q, used_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [COUNT_BITS-1:0] best_val_q, best_val_d;
  logic [KW-1:0]         best_key_q, best_key_d;
  logic                  ovf_q, ovf_d;
  logic                  done_q, done_d;
  logic [COUNT_BITS-1:0] pcount_q, pcount_d;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [RW-1:0]         rdata;
  logic [KW-1:0]         rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  do_hit, do_miss;

  assign rd_key = rdata[RW-1:COUNT_BITS];
  assign rd_cnt = rdata[COUNT_BITS-1:0];

  bfc_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({act_key, new_cnt}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Sequencer and table update
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    key_d      = key_q;
    idx_d      = idx_q;
    used_d     = used_q;
    total_d    = total_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    best_key_d = best_key_q;
    ovf_d      = ovf_q;
    done_d     = 1'b0;
    pcount_d   = pcount_q;
    cmd_pop_o  = 1'b0;
    we         = 1'b0;
    waddr      = idx_q;
    new_cnt    = '0;
    raddr      = idx_q + AW'(1);
    do_hit     = 1'b0;
    do_miss    = 1'b0;
    act_kind   = (state_q == S_IDLE) ? cmd_kind_i : kind_q;
    act_key    = (state_q == S_IDLE) ? cmd_key_i : key_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          kind_d    = cmd_kind_i;
          key_d     = cmd_key_i;
          if (cmd_kind_i == CMD_FIRST) begin
            done_d   = 1'b1;
            pcount_d = '0;
          end else if (used_q == '0) begin
            do_miss = 1'b1;
          end else begin
            raddr   = '0;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_key == key_q) begin
          do_hit = 1'b1;
        end else if ((UW'(idx_q) + UW'(1)) < used_q) begin
          idx_d = idx_q + AW'(1);
        end else begin
          do_miss = 1'b1;
        end
      end
      default: ;
    endcase

    // Hit: count up or report
    if (do_hit) begin
      done_d  = 1'b1;
      state_d = S_IDLE;
      if (act_kind == CMD_QUERY) begin
        pcount_d = rd_cnt;
      end else begin
        pcount_d = '0;
        total_d  = (total_q == CntMax) ? total_q : total_q + COUNT_BITS'(1);
        new_cnt  = (rd_cnt == CntMax) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
        we       = 1'b1;
        waddr    = idx_q;
        if (new_cnt > best_val_q || (new_cnt == best_val_q && idx_q < best_idx_q)) begin
          best_val_d = new_cnt;
          best_idx_d = idx_q;
          best_key_d = act_key;
        end
      end
    end

    // Miss: report a zero count; for a push, allocate a new entry or flag overflow
    if (do_miss) begin
      done_d   = 1'b1;
      state_d  = S_IDLE;
      pcount_d = '0;
      if (act_kind != CMD_QUERY) begin
        total_d = (total_q == CntMax) ? total_q : total_q + COUNT_BITS'(1);
        if (used_q == UW'(TABLE_ENTRIES)) begin
          ovf_d = 1'b1;
        end else begin
          new_cnt = COUNT_BITS'(1);
          we      = 1'b1;
          waddr   = used_q[AW-1:0];
          used_d  = used_q + UW'(1);
          if (new_cnt > best_val_q ||
              (new_cnt == best_val_q && used_q[AW-1:0] < best_idx_q)) begin
            best_val_d = new_cnt;
            best_idx_d = used_q[AW-1:0];
            best_key_d = act_key;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      kind_q     <= CMD_FIRST;
      key_q      <= '0;
      idx_q      <= '0;
      used_q     <= '0;
      total_q    <= '0;
      best_idx_q <= '0;
      best_val_q <= '0;
      best_key_q <= '0;
      ovf_q      <= 1'b0;
      done_q     <= 1'b0;
      pcount_q   <= '0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      key_q      <= key_d;
      idx_q      <= idx_d;
      used_q     <= used_d;
      total_q    <= total_d;
      best_idx_q <= best_idx_d;
      best_val_q <= best_val_d;
      best_key_q <= best_key_d;
      ovf_q      <= ovf_d;
      done_q     <= done_d;
      pcount_q   <= pcount_d;
    end
  end

  assign done_o       = done_q;
  assign pair_count_o = pcount_q;
  assign total_o      = total_q;
  assign best_key_o   = best_key_q;
  assign best_count_o = best_val_q;
  assign overflow_o   = ovf_q;

endmodule

@@ rtl/bigram_frequency_counter.sv @@
// Bigram frequency counter: histogram of adjacent token pairs in a stream.
// Command beats are taken when start is high and busy is low. action_i
// low pushes token_i; each token after the first forms a pair with the
// previous one and is counted in a table of TABLE_ENTRIES distinct pairs.
// action_i high queries the count of (query_first_i, query_second_i).
// Every command gives one result beat, marked by done_o for one cycle, with
// the pair count (zero on a push), the saturating total, the most frequent
// pair and its count, and a sticky table overflow flag.
// A two-beat queue sits between the front end and the table engine, so
// busy rises only when it is full. The engine scans the table one entry
// a cycle through the single read port of the table RAM: a first token,
// or a command on an empty table, is settled in the idle state; others scan
// the used entries until a hit or the last one. The result is registered.
// Reset clears the counters, the previous token and the queue; the table
// itself needs no clearing. Results cannot be held off by the receiver.
// Depends on bfc_pkg, bfc_front, bfc_queue, bfc_back, bfc_ram.
module bigram_frequency_counter
  import bfc_pkg::*;
#(
  parameter int unsigned TOKEN_BITS    = TokenBitsDef,
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned COUNT_BITS    = CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action_i,
  input  logic [FieldBits-1:0] token_i,
  input  logic [FieldBits-1:0] query_first_i,
  input  logic [FieldBits-1:0] query_second_i,
  output logic                 done_o,
  output logic [FieldBits-1:0] pair_count_o,
  output logic [FieldBits-1:0] total_bigrams_o,
  output logic [FieldBits-1:0] best_first_o,
  output logic [FieldBits-1:0] best_second_o,
  output logic [FieldBits-1:0] best_count_o,
  output logic                 table_overflow_o
);

  localparam int unsigned KW = 2 * TOKEN_BITS;
  localparam int unsigned QW = KindBits + KW;

  logic            accept, full, q_valid, q_pop;
  cmd_kind_e       f_kind, q_kind;
  logic [KW-1:0]   f_key, q_key;
  logic [QW-1:0]   q_out;
  logic [COUNT_BITS-1:0] pcount, total, bcount;
  logic [KW-1:0]   bkey;

  assign busy   = full;
  assign accept = start && !full;

  bfc_front #(.TOKEN_BITS(TOKEN_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action_i),
    .token_i       (token_i),
    .query_first_i (query_first_i),
    .query_second_i(query_second_i),
    .kind_o        (f_kind),
    .key_o         (f_key)
  );

  bfc_queue #(.WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i ({f_kind, f_key}),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out),
    .full_o (full)
  );

  assign q_kind = cmd_kind_e'(q_out[QW-1:KW]);
  assign q_key  = q_out[KW-1:0];

  bfc_back #(
    .TOKEN_BITS   (TOKEN_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_kind_i  (q_kind),
    .cmd_key_i   (q_key),
    .cmd_pop_o   (q_pop),
    .done_o      (done_o),
    .pair_count_o(pcount),
    .total_o     (total),
    .best_key_o  (bkey),
    .best_count_o(bcount),
    .overflow_o  (table_overflow_o)
  );

  // Fit internal widths to the result fields
  assign pair_count_o    = FieldBits'(pcount);
  assign total_bigrams_o = FieldBits'(total);
  assign best_first_o    = FieldBits'(bkey[KW-1:TOKEN_BITS]);
  assign best_second_o   = FieldBits'(bkey[TOKEN_BITS-1:0]);
  assign best_count_o    = FieldBits'(bcount);

endmodule
